FILE: sv/srgr_pkg.sv
// ============================================================================
// srgr_pkg - shared definitions for the stereo random glitch repeater
// Register map, register widths and reset values of the control port.
// ============================================================================
package srgr_pkg;

    // Control port
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int REG_IDX_W = 3;

    // Register indexes (byte address = 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_TRIG_PROB  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_JUMP_MIN   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_JUMP_MAX   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SEG_LENGTH = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_REPEAT_CNT = 3'd4;

    // Register widths
    localparam int PROB_W   = 17;
    localparam int JUMP_W   = 16;
    localparam int LENGTH_W = 16;
    localparam int REPEAT_W = 8;
    localparam int RAND_W   = 16;
    localparam int REMAIN_W = LENGTH_W + REPEAT_W;

    // Reset values
    localparam logic [PROB_W-1:0]   PROB_RST   = 17'd6554;
    localparam logic [JUMP_W-1:0]   JUMP_MIN_RST = 16'd2400;
    localparam logic [JUMP_W-1:0]   JUMP_MAX_RST = 16'd16000;
    localparam logic [LENGTH_W-1:0] LENGTH_RST = 16'd2000;
    localparam logic [REPEAT_W-1:0] REPEAT_RST = 8'd2;

    // Per-item control carried from the input stage to the history stage
    typedef struct packed {
        logic              replay;
        logic              trigger;
        logic              wrap;
        logic [JUMP_W-1:0] jump_frac;
    } s1_ctrl_t;

endpackage

FILE: sv/stereo_random_glitch_repeater_core.sv
// ============================================================================
// stereo_random_glitch_repeater_core - random glitch/stutter effect for audio
// Writes every stereo pair into a ring history and, on random triggers,
// replays a segment from further back a programmable number of times.
// ============================================================================
// Usage: one stereo item per clock is sustained while out_ready is held high;
// an accepted item passes the input stage, then the history stage with its
// single registered read per channel, to the result. Throughput is set by the
// history memories, which take one write and one read per item on each side. No
// clearing pass follows reset: a history entry not yet written since reset
// reads back as zero, tracked with the write pointer and a "wrapped once"
// flag. Program the registers only while the block is idle. Trigger test is
// rand_trigger < trigger_probability, taken only when no glitch is playing;
// the triggering item itself passes through and the replay starts with the
// following item. Jump back = jump_min + (rand_jump * (jump_max - jump_min))
// >> 16, with an inverted range read as zero, reduced modulo the history
// depth.
module stereo_random_glitch_repeater_core #(
    parameter int HISTORY_DEPTH = 65536,
    parameter int SAMPLE_BITS   = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,

    // control port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [srgr_pkg::PADDR_W-1:0]        paddr,
    input  logic [srgr_pkg::PDATA_W-1:0]        pwdata,
    output logic [srgr_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready,

    // input items
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [SAMPLE_BITS-1:0]       left_in,
    input  logic signed [SAMPLE_BITS-1:0]       right_in,
    input  logic [srgr_pkg::RAND_W-1:0]         rand_trigger,
    input  logic [srgr_pkg::RAND_W-1:0]         rand_jump,

    // result items
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [SAMPLE_BITS-1:0]       left_out,
    output logic signed [SAMPLE_BITS-1:0]       right_out,
    output logic                                replaying
);

    localparam int ADDR_W  = $clog2(HISTORY_DEPTH);
    localparam int JUMP_W  = srgr_pkg::JUMP_W;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(HISTORY_DEPTH - 1);
    localparam logic [ADDR_W:0]   DEPTH_EXT = (ADDR_W+1)'(HISTORY_DEPTH);

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    logic [srgr_pkg::PROB_W-1:0]   trig_prob_reg;
    logic [JUMP_W-1:0]             jump_min_reg;
    logic [JUMP_W-1:0]             jump_max_reg;
    logic [srgr_pkg::LENGTH_W-1:0] seg_length_reg;
    logic [srgr_pkg::REPEAT_W-1:0] repeat_cnt_reg;

    logic                             cfg_wr;
    logic [srgr_pkg::REG_IDX_W-1:0]   cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[srgr_pkg::PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_prob_reg  <= srgr_pkg::PROB_RST;
            jump_min_reg   <= srgr_pkg::JUMP_MIN_RST;
            jump_max_reg   <= srgr_pkg::JUMP_MAX_RST;
            seg_length_reg <= srgr_pkg::LENGTH_RST;
            repeat_cnt_reg <= srgr_pkg::REPEAT_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                srgr_pkg::REG_TRIG_PROB:  trig_prob_reg  <= pwdata[srgr_pkg::PROB_W-1:0];
                srgr_pkg::REG_JUMP_MIN:   jump_min_reg   <= pwdata[JUMP_W-1:0];
                srgr_pkg::REG_JUMP_MAX:   jump_max_reg   <= pwdata[JUMP_W-1:0];
                srgr_pkg::REG_SEG_LENGTH: seg_length_reg <= pwdata[srgr_pkg::LENGTH_W-1:0];
                srgr_pkg::REG_REPEAT_CNT: repeat_cnt_reg <= pwdata[srgr_pkg::REPEAT_W-1:0];
                default: ;  // unmapped: ignored
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            srgr_pkg::REG_TRIG_PROB:  prdata = srgr_pkg::PDATA_W'(trig_prob_reg);
            srgr_pkg::REG_JUMP_MIN:   prdata = srgr_pkg::PDATA_W'(jump_min_reg);
            srgr_pkg::REG_JUMP_MAX:   prdata = srgr_pkg::PDATA_W'(jump_max_reg);
            srgr_pkg::REG_SEG_LENGTH: prdata = srgr_pkg::PDATA_W'(seg_length_reg);
            srgr_pkg::REG_REPEAT_CNT: prdata = srgr_pkg::PDATA_W'(repeat_cnt_reg);
            default:                  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake: input stage (s1) feeds history stage (s2 = output)
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic in_acc;
    logic s2_adv;

    assign s2_adv   = s1_valid_reg && (!s2_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s2_adv;
    assign in_acc   = in_valid && in_ready;

    // ------------------------------------------------------------------
    // Stage 1: glitch sequencing (offset / remaining count)
    // ------------------------------------------------------------------
    logic [srgr_pkg::LENGTH_W-1:0] seg_offset_reg;
    logic [srgr_pkg::REMAIN_W-1:0] remaining_reg;

    logic                          s1_replay_next;
    logic                          s1_trigger_next;
    logic                          s1_wrap_next;
    logic [srgr_pkg::LENGTH_W:0]   offset_inc;
    logic [JUMP_W-1:0]             jump_spread;
    logic [2*JUMP_W-1:0]           jump_prod;
    logic [srgr_pkg::REMAIN_W-1:0] glitch_len;

    srgr_pkg::s1_ctrl_t            s1_ctrl_reg;
    logic [SAMPLE_BITS-1:0]        s1_left_reg;
    logic [SAMPLE_BITS-1:0]        s1_right_reg;

    always_comb
    begin
        s1_replay_next  = (remaining_reg != '0);
        s1_trigger_next = !s1_replay_next
                          && ({1'b0, rand_trigger} < trig_prob_reg);
        offset_inc      = {1'b0, seg_offset_reg} + 1'b1;
        s1_wrap_next    = (offset_inc >= {1'b0, seg_length_reg});
        jump_spread     = (jump_max_reg > jump_min_reg) ? (jump_max_reg - jump_min_reg) : '0;
        jump_prod       = rand_jump * jump_spread;
        glitch_len      = seg_length_reg * repeat_cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            seg_offset_reg <= '0;
            remaining_reg  <= '0;
        end
        else
        begin
            if (in_acc)
                s1_valid_reg <= 1'b1;
            else if (s2_adv)
                s1_valid_reg <= 1'b0;

            if (in_acc)
            begin
                if (s1_replay_next)
                begin
                    seg_offset_reg <= s1_wrap_next ? '0 : offset_inc[srgr_pkg::LENGTH_W-1:0];
                    remaining_reg  <= remaining_reg - 1'b1;
                end
                else if (s1_trigger_next)
                begin
                    seg_offset_reg <= '0;
                    remaining_reg  <= glitch_len;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_left_reg           <= left_in;
            s1_right_reg          <= right_in;
            s1_ctrl_reg.replay    <= s1_replay_next;
            s1_ctrl_reg.trigger   <= s1_trigger_next;
            s1_ctrl_reg.wrap      <= s1_wrap_next;
            s1_ctrl_reg.jump_frac <= jump_prod[2*JUMP_W-1:JUMP_W];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: history pointers and segment start
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] wr_ptr_reg;     // write index
    logic [ADDR_W-1:0] rd_ptr_reg;     // segment_start + segment_offset
    logic [ADDR_W-1:0] seg_start_reg;
    logic              hist_full_reg;  // every entry written at least once

    logic [JUMP_W-1:0] jump_abs;
    logic [JUMP_W-1:0] jump_red [0:8];
    logic [ADDR_W-1:0] jump_back;
    logic [ADDR_W:0]   start_diff;
    logic [ADDR_W-1:0] start_next;
    logic [ADDR_W-1:0] wr_ptr_inc;
    logic [ADDR_W-1:0] rd_ptr_inc;

    // jump < 2^16 and the depth is at least 256, so at most eight
    // conditional subtracts reduce it below the depth
    assign jump_abs    = jump_min_reg + s1_ctrl_reg.jump_frac;
    assign jump_red[8] = jump_abs;

    for (genvar i = 0; i < 8; i++)
    begin : g_mod
        localparam longint unsigned STEP = longint'(HISTORY_DEPTH) << i;
        if (STEP < 65536)
        begin : g_sub
            assign jump_red[i] = (jump_red[i+1] >= JUMP_W'(STEP))
                                 ? (jump_red[i+1] - JUMP_W'(STEP)) : jump_red[i+1];
        end
        else
        begin : g_pass
            assign jump_red[i] = jump_red[i+1];
        end
    end

    always_comb
    begin
        jump_back  = ADDR_W'(jump_red[0]);
        start_diff = {1'b0, wr_ptr_reg} - {1'b0, jump_back};
        if (start_diff[ADDR_W])
            start_diff = start_diff + DEPTH_EXT;
        start_next = start_diff[ADDR_W-1:0];
        wr_ptr_inc = (wr_ptr_reg == LAST_ADDR) ? '0 : (wr_ptr_reg + 1'b1);
        rd_ptr_inc = (rd_ptr_reg == LAST_ADDR) ? '0 : (rd_ptr_reg + 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            seg_start_reg <= '0;
            hist_full_reg <= 1'b0;
        end
        else
        begin
            if (s2_adv)
                s2_valid_reg <= 1'b1;
            else if (out_ready)
                s2_valid_reg <= 1'b0;

            if (s2_adv)
            begin
                wr_ptr_reg <= wr_ptr_inc;
                if (wr_ptr_reg == LAST_ADDR)
                    hist_full_reg <= 1'b1;

                if (s1_ctrl_reg.trigger)
                begin
                    seg_start_reg <= start_next;
                    rd_ptr_reg    <= start_next;
                end
                else if (s1_ctrl_reg.replay)
                begin
                    // wrap returns to the segment start for the next pass
                    rd_ptr_reg <= s1_ctrl_reg.wrap ? seg_start_reg : rd_ptr_inc;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // History memories: one write and one registered read per item
    // ------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] left_mem  [HISTORY_DEPTH];
    logic [SAMPLE_BITS-1:0] right_mem [HISTORY_DEPTH];
    logic [SAMPLE_BITS-1:0] rd_left_reg;
    logic [SAMPLE_BITS-1:0] rd_right_reg;

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            left_mem[wr_ptr_reg]  <= s1_left_reg;
            right_mem[wr_ptr_reg] <= s1_right_reg;
            rd_left_reg           <= left_mem[rd_ptr_reg];
            rd_right_reg          <= right_mem[rd_ptr_reg];
        end
    end

    // Output stage payload
    logic [SAMPLE_BITS-1:0] s2_left_reg;
    logic [SAMPLE_BITS-1:0] s2_right_reg;
    logic                   s2_replay_reg;
    logic                   s2_bypass_reg;  // read hits the entry written now
    logic                   s2_blank_reg;   // entry never written since reset

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            s2_left_reg   <= s1_left_reg;
            s2_right_reg  <= s1_right_reg;
            s2_replay_reg <= s1_ctrl_reg.replay;
            s2_bypass_reg <= (rd_ptr_reg == wr_ptr_reg);
            s2_blank_reg  <= !hist_full_reg && (rd_ptr_reg > wr_ptr_reg);
        end
    end

    always_comb
    begin
        if (!s2_replay_reg || s2_bypass_reg)
        begin
            left_out  = s2_left_reg;
            right_out = s2_right_reg;
        end
        else if (s2_blank_reg)
        begin
            left_out  = '0;
            right_out = '0;
        end
        else
        begin
            left_out  = rd_left_reg;
            right_out = rd_right_reg;
        end
    end

    assign out_valid = s2_valid_reg;
    assign replaying = s2_replay_reg;

endmodule

FILE: sv/srgr_checker.sv
// ============================================================================
// srgr_checker - port-level checks for the glitch repeater
// Watches the top-level ports for handshake and pipeline-occupancy slips.
// ============================================================================
module srgr_port_checks #(
    parameter int SAMPLE_BITS = 24
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          psel,
    input logic                          pready,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [SAMPLE_BITS-1:0]        left_out,
    input logic [SAMPLE_BITS-1:0]        right_out,
    input logic                          replaying
);

    // control port never inserts wait states
    a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
        psel |-> pready)
        else $error("pready dropped during a control access");

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(left_out)
                                    && $stable(right_out) && $stable(replaying))
        else $error("result changed while stalled");

    // empty output stage means the pipeline can take an item
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output stage");

    // no result appears without an accepted item passing through the input stage first
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid && !(in_valid && in_ready)) ##1 !out_valid |=> !out_valid)
        else $error("result appeared with no item in flight");

endmodule

bind stereo_random_glitch_repeater_core srgr_port_checks #(
    .SAMPLE_BITS(SAMPLE_BITS)
) u_srgr_port_checks (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .left_out  (left_out),
    .right_out (right_out),
    .replaying (replaying)
);
